// File: rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam int VALUE_W    = 32;
   localparam int PRIO_W     = 16;
   localparam int COUNT_W    = 5;
   localparam int ERR_W      = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;

   // operation carried in tuser
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK        = 2'd0,
      ERR_POP_EMPTY = 2'd1,
      ERR_PUSH_FULL = 2'd2
   } err_type;

   // controller to datapath
   typedef struct packed {
      logic    exec;
      logic    push;
      logic    pop;
      err_type err;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/sorted_priority_queue_top.sv
`default_nettype none

// sorted priority queue, lowest priority value served first
// req channel: one word per operation, tuser selects push (0) or pop (1);
//   a push carries value and priority in tdata, a pop ignores tdata
// rsp channel: exactly one word per request word, in order, giving the
//   popped value, the head value, non-empty flag, entry count and error
// entries sit in a chain of cells; every cell compares its priority with
//   the incoming one in parallel, so an insert or a removal is one shift
// latency: the response is valid in the cycle after the request is taken
// throughput: one request per cycle; the response register is the only
//   buffer, so a new request is taken while the old response is being read
// receiver stall: while rsp_tready is low the response holds and
//   req_tready drops until it is taken
// errors: pop on empty leaves the queue as it is and reports pop-empty;
//   push on full drops the entry and reports push-full
// reset: synchronous, empties the queue and clears the response valid;
//   cell contents are not cleared, only occupied cells are ever read
module sorted_priority_queue_top #(
   parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                             clock,
   input  wire                             reset,
   // request: tdata = value[31:0], priority_req[47:32]; tuser = func
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire  [spq_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire                             req_tuser,
   // response: tdata = popped_value[31:0], head_value[63:32],
   //   not_empty[64], entry_count[69:65], error_code[71:70]
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [spq_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   spq_pkg::cmd_type    cmd;
   spq_pkg::status_type status;

   // handshakes, op decoding and error classification
   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // cell chain, occupancy count and response register
   spq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: rtl/spq_ctrl.sv
`default_nettype none

module spq_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire                 req_tuser,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   input  spq_pkg::status_type status,
   output spq_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_HOLD = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      exec;

   assign req_tready = (state_ff == ST_IDLE) || rsp_tready;
   assign rsp_tvalid = (state_ff == ST_HOLD);
   assign exec       = req_tvalid && req_tready;

   always_comb begin
      cmd.exec = exec;
      cmd.push = 1'b0;
      cmd.pop  = 1'b0;
      cmd.err  = spq_pkg::ERR_OK;
      if (req_tuser == spq_pkg::FUNC_PUSH) begin
         if (status.full) begin
            cmd.err = spq_pkg::ERR_PUSH_FULL;
         end else begin
            cmd.push = exec;
         end
      end else begin
         if (status.empty) begin
            cmd.err = spq_pkg::ERR_POP_EMPTY;
         end else begin
            cmd.pop = exec;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (exec) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!exec && rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/spq_datapath.sv
`default_nettype none

module spq_datapath #(
   parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire  [spq_pkg::REQ_DATA_W-1:0]         req_tdata,
   input  spq_pkg::cmd_type                       cmd,
   output spq_pkg::status_type                    status,
   output logic [spq_pkg::RSP_DATA_W-1:0]         rsp_tdata
);

   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int VW    = spq_pkg::VALUE_W;
   localparam int PW    = spq_pkg::PRIO_W;
   localparam int CW    = spq_pkg::COUNT_W;

   logic        [VW-1:0] val_ff  [QUEUE_DEPTH];
   logic        [VW-1:0] val_in  [QUEUE_DEPTH];
   logic signed [PW-1:0] prio_ff [QUEUE_DEPTH];
   logic signed [PW-1:0] prio_in [QUEUE_DEPTH];
   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic [spq_pkg::RSP_DATA_W-1:0] rsp_ff;

   logic        [VW-1:0] new_val;
   logic signed [PW-1:0] new_prio;
   logic [QUEUE_DEPTH-1:0] at_or_after;   // insertion point at or before this cell
   logic [VW-1:0]          popped;
   logic [VW-1:0]          head;
   logic [CW+OCC_W-1:0]    count_ext;

   assign new_val  = req_tdata[VW-1:0];
   assign new_prio = req_tdata[VW+PW-1:VW];

   assign status.full  = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign status.empty = (occ_ff == '0);

   // the new entry takes the head only on a strictly smaller priority
   assign at_or_after[0] = status.empty || (new_prio < prio_ff[0]);

   genvar g;
   generate
      for (g = 1; g < QUEUE_DEPTH; g++) begin : g_cmp
         assign at_or_after[g] = at_or_after[0] || (OCC_W'(g) >= occ_ff)
                                 || (prio_ff[g] >= new_prio);
      end

      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         always_comb begin
            val_in[g]  = val_ff[g];
            prio_in[g] = prio_ff[g];
            if (cmd.push) begin
               if (g > 0 && at_or_after[(g > 0) ? g - 1 : 0]) begin
                  val_in[g]  = val_ff[(g > 0) ? g - 1 : 0];
                  prio_in[g] = prio_ff[(g > 0) ? g - 1 : 0];
               end else if (at_or_after[g]) begin
                  val_in[g]  = new_val;
                  prio_in[g] = new_prio;
               end
            end else if (cmd.pop && g < QUEUE_DEPTH - 1) begin
               val_in[g]  = val_ff[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
               prio_in[g] = prio_ff[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
            end
         end

         always_ff @(posedge clock) begin
            val_ff[g]  <= val_in[g];
            prio_ff[g] <= prio_in[g];
         end
      end
   endgenerate

   always_comb begin
      occ_in = occ_ff;
      if (cmd.push) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (cmd.pop) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   assign popped    = cmd.pop ? val_ff[0] : '0;
   assign head      = (occ_in != '0) ? val_in[0] : '0;
   assign count_ext = {{CW{1'b0}}, occ_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= {cmd.err, count_ext[CW-1:0], (occ_in != '0), head, popped};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

`default_nettype wire

// File: dv/tb_sorted_priority_queue_top.sv
`default_nettype none

module tb_sorted_priority_queue_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH           = spq_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int VALUE_W         = spq_pkg::VALUE_W;
   localparam int PRIO_W          = spq_pkg::PRIO_W;
   localparam int COUNT_W         = spq_pkg::COUNT_W;
   localparam int WORDS_PER_PHASE = 400;
   localparam int SETTLE_CYCLES   = 10;   // keep some margin before the end of the run

   // one request word as the testbench sees it
   typedef struct packed {
      logic                     func;
      logic [VALUE_W-1:0]       value;
      logic signed [PRIO_W-1:0] prio;
   } op_word_type;

   // one queue entry held by the predictor
   typedef struct packed {
      logic [VALUE_W-1:0]       value;
      logic signed [PRIO_W-1:0] prio;
   } entry_type;

   // response word, members listed from the top bit down to match rsp_tdata
   typedef struct packed {
      spq_pkg::err_type     err;
      logic [COUNT_W-1:0]   count;
      logic                 not_empty;
      logic [VALUE_W-1:0]   head;
      logic [VALUE_W-1:0]   popped;
   } status_word_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [spq_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tuser  = spq_pkg::FUNC_PUSH;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [spq_pkg::RSP_DATA_W-1:0] rsp_tdata;

   op_word_type     op_words_pending[$];    // words waiting for the driver
   status_word_type status_expected[$];     // predicted responses, oldest first
   entry_type       model_entries[$];       // predicted queue contents, head first
   int unsigned  send_idle_pct  = 0;
   int unsigned  recv_stall_pct = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  rsp_word_index = 0;
   bit           word_taken     = 1'b0;  // request handshake seen at the last rising edge

   sorted_priority_queue_top #(
      .QUEUE_DEPTH (DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // value[31:0], priority_req[47:32]
      .req_tuser  (req_tuser),   // func
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // popped[31:0], head[63:32], not_empty[64], count[69:65], err[71:70]
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: response word %0d: %s", $time, rsp_word_index, msg);
      mismatch_count++;
   endtask

   // queue behaviour: push inserts in ascending priority order, with a tie on
   // the head going behind it; pop takes the head; full and empty are errors
   function automatic status_word_type apply_queue_op(input op_word_type op);
      status_word_type res;
      entry_type       ent;
      int              pos;
      int              n;
      res = '0;
      res.err = spq_pkg::ERR_OK;
      if (op.func == spq_pkg::FUNC_PUSH) begin
         if (model_entries.size() >= DEPTH) begin
            res.err = spq_pkg::ERR_PUSH_FULL;
         end else begin
            if (model_entries.size() == 0 ||
                $signed(op.prio) < $signed(model_entries[0].prio)) begin
               pos = 0;
            end else begin
               pos = 1;
               while (pos < model_entries.size() &&
                      $signed(model_entries[pos].prio) < $signed(op.prio))
                  pos++;
            end
            ent.value = op.value;
            ent.prio  = op.prio;
            model_entries.insert(pos, ent);
         end
      end else begin
         if (model_entries.size() == 0) begin
            res.err = spq_pkg::ERR_POP_EMPTY;
         end else begin
            ent = model_entries.pop_front();
            res.popped = ent.value;
         end
      end
      n = model_entries.size();
      if (n != 0) begin
         res.head      = model_entries[0].value;
         res.not_empty = 1'b1;
      end
      res.count = n[COUNT_W-1:0];
      return res;
   endfunction

   function automatic void queue_push(input logic [VALUE_W-1:0] value,
                                      input logic signed [PRIO_W-1:0] prio);
      op_word_type op;
      op.func  = spq_pkg::FUNC_PUSH;
      op.value = value;
      op.prio  = prio;
      op_words_pending.push_back(op);
   endfunction

   // tdata of a pop is junk, the block should ignore it
   function automatic void queue_pop();
      op_word_type op;
      op.func  = spq_pkg::FUNC_POP;
      op.value = VALUE_W'($urandom);
      op.prio  = PRIO_W'($urandom);
      op_words_pending.push_back(op);
   endfunction

   // wait until every queued word has gone in and every response come out
   task automatic wait_drained();
      while (op_words_pending.size() != 0 || req_tvalid || status_expected.size() != 0)
         @(negedge clock);
   endtask

   // driver: new word or idle at the falling edge, once the last one was taken
   always @(negedge clock) begin : driver
      op_word_type next_op;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || word_taken) begin
         if (op_words_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_op = op_words_pending.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_op.func;
            req_tdata  <= {next_op.prio, next_op.value};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: check responses and predict from accepted requests at the rising edge
   always @(posedge clock) begin : monitor
      status_word_type got;
      status_word_type want;
      op_word_type     taken_op;
      if (reset) begin
         word_taken = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = status_word_type'(rsp_tdata);
            if (status_expected.size() == 0) begin
               report_mismatch("response word with nothing expected");
            end else begin
               want = status_expected.pop_front();
               if (got.popped !== want.popped)
                  report_mismatch($sformatf("popped_value %h, expected %h",
                                            got.popped, want.popped));
               if (got.head !== want.head)
                  report_mismatch($sformatf("head_value %h, expected %h", got.head, want.head));
               if (got.not_empty !== want.not_empty)
                  report_mismatch($sformatf("not_empty %b, expected %b",
                                            got.not_empty, want.not_empty));
               if (got.count !== want.count)
                  report_mismatch($sformatf("entry_count %0d, expected %0d",
                                            got.count, want.count));
               if (got.err !== want.err)
                  report_mismatch($sformatf("error_code %0d, expected %0d", got.err, want.err));
            end
            rsp_word_index++;
         end
         word_taken = req_tvalid && req_tready;
         if (word_taken) begin
            taken_op.func  = req_tuser;
            taken_op.value = req_tdata[VALUE_W-1:0];
            taken_op.prio  = req_tdata[VALUE_W +: PRIO_W];
            status_expected.push_back(apply_queue_op(taken_op));
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int unsigned send_pct[4];
      int unsigned recv_pct[4];
      int unsigned push_pct;
      int unsigned pick;
      int          tie_prio;
      logic [VALUE_W-1:0]       value;
      logic signed [PRIO_W-1:0] prio;

      // idling phases: none, sender gaps, receiver stalls, both
      send_pct = '{0, 56, 0, 24};
      recv_pct = '{0, 0, 56, 24};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words, no idling
      queue_pop();                                  // pop on empty queue
      queue_push(32'h7fff_ffff, 16'sd0);            // push into empty queue
      queue_push(32'h8000_0000, 16'sd0);            // tie with head, goes behind it
      queue_push(32'h0000_0001, -16'sd32768);       // strictly below head, new head
      queue_push(32'hffff_ffff, 16'sd32767);        // largest priority, lands at tail
      queue_push(32'h0000_0000, 16'sd0);            // ties the entries behind head, goes before them
      queue_pop();
      queue_pop();
      for (int k = 0; k < 13; k++)                  // fill up to the depth, descending
         queue_push(32'h5a5a_0000 + k, 16'(12 - k));
      queue_push(32'hdead_beef, -16'sd1);           // push on full queue, dropped
      queue_pop();
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = send_pct[ph];
         recv_stall_pct = recv_pct[ph];
         push_pct = 55;
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            // runs of filling, draining or balanced traffic so full and empty both come up
            if (i % 40 == 0) begin
               case ($urandom_range(2))
                  0:       push_pct = 80;
                  1:       push_pct = 25;
                  default: push_pct = 55;
               endcase
            end
            if ($urandom_range(99) < push_pct) begin
               case ($urandom_range(9))
                  0:       value = 32'h8000_0000;
                  1:       value = 32'h7fff_ffff;
                  default: value = VALUE_W'($urandom);
               endcase
               pick = $urandom_range(9);
               if (pick < 5) begin
                  // narrow range so ties are common
                  tie_prio = int'($urandom_range(6));
                  prio = PRIO_W'(tie_prio - 3);
               end else if (pick == 5) begin
                  prio = -16'sd32768;
               end else if (pick == 6) begin
                  prio = 16'sd32767;
               end else begin
                  prio = PRIO_W'($urandom);
               end
               queue_push(value, prio);
            end else begin
               queue_pop();
            end
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
